FILE: hdl/mmh_pkg.sv
// shared constants, state codes and control structs for the murmur hash block
package mmh_pkg;

  localparam logic [63:0] MulConst   = 64'hc6a4a7935bd1e995;
  localparam int          ShiftConst = 47;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_LEN_MUL,
    ST_LEN_WB,
    ST_KEY_MUL,
    ST_KEY_WB,
    ST_MIX_MUL,
    ST_MIX_WB,
    ST_TAIL,
    ST_ACC_MUL,
    ST_ACC_WB,
    ST_FIN_MUL,
    ST_FIN_WB
  } state_t;

  // multiplier operand source
  typedef enum logic [2:0] {
    OP_LENGTH,
    OP_DATA,
    OP_WORK,
    OP_ACCUM,
    OP_FINAL
  } operand_t;

  // destination of the multiplier result
  typedef enum logic [2:0] {
    WB_NONE,
    WB_SEED,
    WB_KEY,
    WB_MIX,
    WB_ACCUM,
    WB_TAIL,
    WB_OUT
  } wb_t;

  typedef struct packed {
    logic     capture;
    logic     mul_issue;
    operand_t operand;
    wb_t      wb;
  } ctrl_cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic count_full;
    logic count_zero;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: hdl/murmur_hash_64a.sv
// top level of the streaming murmur hash 64a engine
// the single shared multiplier limits the block to one item at a time, taken only in idle;
//   a full word takes three multiplies, a tail word one, an empty word none, seed load and
//   finalization one each, a dropped item is accepted and discarded; a busy output holds
//   finalization until the receiver takes the previous hash
// reset: synchronous active-high rst clears seed, accumulator, length counters and message state
module murmur_hash_64a #(
  parameter int LENGTH_WIDTH = 31,
  localparam int InDataWidth = ((68 + LENGTH_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,

  // seed register write
  input  logic                   cfg_wr_en,
  input  logic [63:0]            cfg_wr_data,

  // item input
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // word_data [63:0], byte_count [67:64], total_length above, zero padded to bytes
  input  logic [InDataWidth-1:0] s_axis_tdata,
  // first_word
  input  logic                   s_axis_tuser,
  // last_word
  input  logic                   s_axis_tlast,

  // hash output
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // hash_value [63:0]
  output logic [63:0]            m_axis_tdata,
  // length_mismatch
  output logic                   m_axis_tuser
);

  mmh_pkg::ctrl_cmd_t  cmd;
  mmh_pkg::dp_status_t status;

  // sequencer: decides which multiply runs next and where the result lands
  mmh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_first (s_axis_tuser),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: captured item, accumulator, shared multiplier and output register
  mmh_datapath #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_data      (s_axis_tdata[63:0]),
    .in_count     (s_axis_tdata[67:64]),
    .in_first     (s_axis_tuser),
    .in_last      (s_axis_tlast),
    .in_total     (s_axis_tdata[68 +: LENGTH_WIDTH]),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_hash     (m_axis_tdata),
    .out_mismatch (m_axis_tuser)
  );

endmodule

FILE: hdl/mmh_mul.sv
// 64-bit multiply by the hash constant, low half only, from registered 32x32 partials
module mmh_mul (
  input  logic        clk,
  input  logic        issue,
  input  logic [63:0] operand,
  output logic [63:0] product
);

  logic [63:0] part_lo;
  logic [31:0] cross_a;
  logic [31:0] cross_b;

  always_ff @(posedge clk) begin
    if (issue) begin
      part_lo <= 64'(operand[31:0]) * 64'(mmh_pkg::MulConst[31:0]);
      cross_a <= operand[63:32] * mmh_pkg::MulConst[31:0];
      cross_b <= operand[31:0] * mmh_pkg::MulConst[63:32];
    end
  end

  assign product = part_lo + {cross_a + cross_b, 32'b0};

endmodule

FILE: hdl/mmh_datapath.sv
// item capture, accumulator, length bookkeeping and result register
module mmh_datapath #(
  parameter int LENGTH_WIDTH = 31
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [63:0]             cfg_wr_data,
  input  logic [63:0]             in_data,
  input  logic [3:0]              in_count,
  input  logic                    in_first,
  input  logic                    in_last,
  input  logic [LENGTH_WIDTH-1:0] in_total,
  input  mmh_pkg::ctrl_cmd_t      cmd,
  output mmh_pkg::dp_status_t     status,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [63:0]             out_hash,
  output logic                    out_mismatch
);

  logic [63:0]             seed;
  logic [63:0]             cap_data;
  logic [3:0]              cap_count;
  logic                    cap_first;
  logic                    cap_last;
  logic [LENGTH_WIDTH-1:0] cap_total;
  logic [63:0]             accum;
  logic [63:0]             work;
  logic [LENGTH_WIDTH-1:0] bytes_seen;
  logic [LENGTH_WIDTH-1:0] expected_length;

  logic [3:0]              count_clamped;
  logic [LENGTH_WIDTH-1:0] seen_base;
  logic [LENGTH_WIDTH:0]   seen_sum;
  logic [LENGTH_WIDTH-1:0] bytes_seen_next;
  logic [63:0]             mul_operand;
  logic [63:0]             product;
  logic [63:0]             product_fold;
  logic [63:0]             tail_mask;

  assign count_clamped = in_count[3] ? 4'd8 : in_count;

  // saturating byte counter, restarted by a first item
  always_comb begin
    seen_base = in_first ? '0 : bytes_seen;
    seen_sum  = {1'b0, seen_base} + (LENGTH_WIDTH + 1)'(count_clamped);
    bytes_seen_next = seen_sum[LENGTH_WIDTH] ? '1 : seen_sum[LENGTH_WIDTH-1:0];
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      tail_mask[i*8 +: 8] = (4'(i) < cap_count) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    unique case (cmd.operand)
      mmh_pkg::OP_LENGTH: mul_operand = 64'(cap_total);
      mmh_pkg::OP_DATA:   mul_operand = cap_data;
      mmh_pkg::OP_WORK:   mul_operand = work;
      mmh_pkg::OP_ACCUM:  mul_operand = accum;
      mmh_pkg::OP_FINAL:  mul_operand = accum ^ (accum >> mmh_pkg::ShiftConst);
      default:            mul_operand = accum;
    endcase
  end

  mmh_mul u_mul (
    .clk     (clk),
    .issue   (cmd.mul_issue),
    .operand (mul_operand),
    .product (product)
  );

  assign product_fold = product ^ (product >> mmh_pkg::ShiftConst);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed            <= '0;
      bytes_seen      <= '0;
      expected_length <= '0;
      accum           <= '0;
    end else begin
      if (cfg_wr_en) begin
        seed <= cfg_wr_data;
      end
      if (cmd.capture) begin
        bytes_seen <= bytes_seen_next;
        if (in_first) begin
          expected_length <= in_total;
        end
      end
      unique case (cmd.wb)
        mmh_pkg::WB_SEED:  accum <= seed ^ product;
        mmh_pkg::WB_MIX:   accum <= accum ^ product;
        mmh_pkg::WB_ACCUM: accum <= product;
        mmh_pkg::WB_TAIL:  accum <= accum ^ (cap_data & tail_mask);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_data  <= in_data;
      cap_count <= count_clamped;
      cap_first <= in_first;
      cap_last  <= in_last;
      cap_total <= in_total;
    end
    if (cmd.wb == mmh_pkg::WB_KEY) begin
      work <= product_fold;
    end
    if (cmd.wb == mmh_pkg::WB_OUT) begin
      out_hash     <= product_fold;
      out_mismatch <= (bytes_seen != expected_length);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.wb == mmh_pkg::WB_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    status.first      = cap_first;
    status.last       = cap_last;
    status.count_full = cap_count[3];
    status.count_zero = (cap_count == 4'd0);
    status.out_busy   = out_valid & ~out_ready;
  end

endmodule

FILE: hdl/mmh_ctrl.sv
// sequencer that steps one item through the shared multiplier
module mmh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_first,
  input  logic                in_last,
  output logic                in_ready,
  input  mmh_pkg::dp_status_t status,
  output mmh_pkg::ctrl_cmd_t  cmd
);

  mmh_pkg::state_t state;
  mmh_pkg::state_t state_next;
  logic            in_message;
  logic            in_message_next;

  // step after the seed is loaded or straight after capture
  function automatic mmh_pkg::state_t route(mmh_pkg::dp_status_t s);
    mmh_pkg::state_t r;
    priority if (s.count_full) begin
      r = mmh_pkg::ST_KEY_MUL;
    end else if (!s.count_zero) begin
      r = mmh_pkg::ST_TAIL;
    end else if (s.last) begin
      r = mmh_pkg::ST_FIN_MUL;
    end else begin
      r = mmh_pkg::ST_IDLE;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mmh_pkg::ST_IDLE;
      in_message <= 1'b0;
    end else begin
      state      <= state_next;
      in_message <= in_message_next;
    end
  end

  always_comb begin
    state_next      = state;
    in_message_next = in_message;
    unique case (state)
      mmh_pkg::ST_IDLE: begin
        if (in_valid && (in_first || in_message)) begin
          state_next      = mmh_pkg::ST_START;
          in_message_next = ~in_last;
        end
      end
      mmh_pkg::ST_START:   state_next = status.first ? mmh_pkg::ST_LEN_MUL : route(status);
      mmh_pkg::ST_LEN_MUL: state_next = mmh_pkg::ST_LEN_WB;
      mmh_pkg::ST_LEN_WB:  state_next = route(status);
      mmh_pkg::ST_KEY_MUL: state_next = mmh_pkg::ST_KEY_WB;
      mmh_pkg::ST_KEY_WB:  state_next = mmh_pkg::ST_MIX_MUL;
      mmh_pkg::ST_MIX_MUL: state_next = mmh_pkg::ST_MIX_WB;
      mmh_pkg::ST_MIX_WB:  state_next = mmh_pkg::ST_ACC_MUL;
      mmh_pkg::ST_TAIL:    state_next = mmh_pkg::ST_ACC_MUL;
      mmh_pkg::ST_ACC_MUL: state_next = mmh_pkg::ST_ACC_WB;
      mmh_pkg::ST_ACC_WB:  state_next = status.last ? mmh_pkg::ST_FIN_MUL : mmh_pkg::ST_IDLE;
      mmh_pkg::ST_FIN_MUL: state_next = mmh_pkg::ST_FIN_WB;
      mmh_pkg::ST_FIN_WB:  state_next = status.out_busy ? mmh_pkg::ST_FIN_WB : mmh_pkg::ST_IDLE;
      default:             state_next = mmh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.capture   = 1'b0;
    cmd.mul_issue = 1'b0;
    cmd.operand   = mmh_pkg::OP_ACCUM;
    cmd.wb        = mmh_pkg::WB_NONE;
    unique case (state)
      mmh_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid & (in_first | in_message);
      end
      mmh_pkg::ST_LEN_MUL: begin
        cmd.mul_issue = 1'b1;
        cmd.operand   = mmh_pkg::OP_LENGTH;
      end
      mmh_pkg::ST_LEN_WB: cmd.wb = mmh_pkg::WB_SEED;
      mmh_pkg::ST_KEY_MUL: begin
        cmd.mul_issue = 1'b1;
        cmd.operand   = mmh_pkg::OP_DATA;
      end
      mmh_pkg::ST_KEY_WB: cmd.wb = mmh_pkg::WB_KEY;
      mmh_pkg::ST_MIX_MUL: begin
        cmd.mul_issue = 1'b1;
        cmd.operand   = mmh_pkg::OP_WORK;
      end
      mmh_pkg::ST_MIX_WB: cmd.wb = mmh_pkg::WB_MIX;
      mmh_pkg::ST_TAIL:   cmd.wb = mmh_pkg::WB_TAIL;
      mmh_pkg::ST_ACC_MUL: begin
        cmd.mul_issue = 1'b1;
        cmd.operand   = mmh_pkg::OP_ACCUM;
      end
      mmh_pkg::ST_ACC_WB: cmd.wb = mmh_pkg::WB_ACCUM;
      mmh_pkg::ST_FIN_MUL: begin
        cmd.mul_issue = 1'b1;
        cmd.operand   = mmh_pkg::OP_FINAL;
      end
      mmh_pkg::ST_FIN_WB: cmd.wb = status.out_busy ? mmh_pkg::WB_NONE : mmh_pkg::WB_OUT;
      default: ;
    endcase
  end

endmodule

FILE: tb/sv/mmh_digest_check.sv
// checker that predicts murmur hash 64a digests from the item stream and compares them
module mmh_digest_check #(
  parameter int LENGTH_WIDTH = 31,
  localparam int InDataWidth = ((68 + LENGTH_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [63:0]            cfg_wr_data,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [InDataWidth-1:0] s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tlast,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [63:0]            m_axis_tdata,
  input  logic                   m_axis_tuser,
  output int                     errors,
  output int                     pending,
  output int                     digests_seen,
  output int                     flags_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [LENGTH_WIDTH-1:0] LenMax = '1;

  typedef struct packed {
    logic [63:0] hash;
    logic        mismatch;
  } digest_t;

  logic [63:0]             seed;
  logic [63:0]             accum;
  logic [LENGTH_WIDTH-1:0] seen_len;
  logic [LENGTH_WIDTH-1:0] stated_len;
  logic                    open_msg;
  digest_t                 digest_queue[$];
  int                      err_cnt;
  int                      seen_cnt;
  int                      flag_cnt;

  function automatic logic [63:0] scramble_key(input logic [63:0] k);
    logic [63:0] t;
    t = k * mmh_pkg::MulConst;
    t = t ^ (t >> mmh_pkg::ShiftConst);
    t = t * mmh_pkg::MulConst;
    return t;
  endfunction

  function automatic logic [63:0] avalanche(input logic [63:0] h);
    logic [63:0] t;
    t = h ^ (h >> mmh_pkg::ShiftConst);
    t = t * mmh_pkg::MulConst;
    t = t ^ (t >> mmh_pkg::ShiftConst);
    return t;
  endfunction

  always @(posedge clk) begin : track
    digest_t                 want;
    logic [63:0]             word;
    logic [63:0]             mask;
    logic [3:0]              cnt;
    logic [LENGTH_WIDTH-1:0] total;
    logic                    live;
    logic                    bad;
    if (rst) begin
      seed       = '0;
      accum      = '0;
      seen_len   = '0;
      stated_len = '0;
      open_msg   = 1'b0;
      digest_queue.delete();
    end else begin
      if (cfg_wr_en) begin
        seed = cfg_wr_data;
      end

      // retire a digest before taking a new item, the output always belongs to older input
      if (m_axis_tvalid && m_axis_tready) begin
        seen_cnt++;
        if (m_axis_tuser) begin
          flag_cnt++;
        end
        if (digest_queue.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("unexpected digest %h flag %b at %0t", m_axis_tdata, m_axis_tuser, $time);
          end
        end else begin
          want = digest_queue.pop_front();
          bad  = 1'b0;
          if (m_axis_tdata !== want.hash) begin
            bad = 1'b1;
          end
          if (m_axis_tuser !== want.mismatch) begin
            bad = 1'b1;
          end
          if (bad) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("digest mismatch at %0t: hash expected %h got %h, flag expected %b got %b",
                       $time, want.hash, m_axis_tdata, want.mismatch, m_axis_tuser);
            end
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        word  = s_axis_tdata[63:0];
        cnt   = s_axis_tdata[67:64];
        total = s_axis_tdata[68 +: LENGTH_WIDTH];
        live  = 1'b1;
        if (cnt > 4'd8) begin
          cnt = 4'd8;
        end
        if (s_axis_tuser) begin
          stated_len = total;
          seen_len   = '0;
          accum      = seed ^ (64'(total) * mmh_pkg::MulConst);
          open_msg   = 1'b1;
        end else if (!open_msg) begin
          live = 1'b0;
        end
        if (live) begin
          if (cnt == 4'd8) begin
            accum = (accum ^ scramble_key(word)) * mmh_pkg::MulConst;
          end else if (cnt != 4'd0) begin
            mask  = ~64'd0 >> (64 - 8 * int'(cnt));
            accum = (accum ^ (word & mask)) * mmh_pkg::MulConst;
          end
          if (LenMax - seen_len < cnt) begin
            seen_len = LenMax;
          end else begin
            seen_len = seen_len + cnt;
          end
          if (s_axis_tlast) begin
            open_msg      = 1'b0;
            want.hash     = avalanche(accum);
            want.mismatch = (seen_len != stated_len);
            digest_queue.insert(digest_queue.size(), want);
          end
        end
      end
    end
    errors       <= err_cnt;
    pending      <= digest_queue.size();
    digests_seen <= seen_cnt;
    flags_seen   <= flag_cnt;
  end

endmodule

FILE: tb/sv/tb_top.sv
// top of the murmur hash 64a testbench: clock, reset, seed writes, item stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LenW        = 31;
  localparam int DataW       = ((68 + LenW + 7) / 8) * 8;
  localparam int DrainCycles = 40;     // well past the worst case per item
  localparam int HoldCycles  = 400;    // long receiver hold-off
  localparam int CycleLimit  = 600000;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  logic [63:0]      cfg_wr_data;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata;   // word_data, byte_count, total_length, zero pad
  logic             s_axis_tuser;   // first_word
  logic             s_axis_tlast;   // last_word
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [63:0]      m_axis_tdata;   // hash_value
  logic             m_axis_tuser;   // length_mismatch

  int errors;
  int pending;
  int digests_seen;
  int flags_seen;

  // shared between the sender and the receiver process
  bit calm = 1'b0;          // no idling on either side
  int hold_requests = 0;    // bumped by the sender to ask for a long hold-off
  int holds_done = 0;

  // bookkeeping for the summary
  int  items_sent = 0;
  int  items_ignored = 0;
  int  seeds_loaded = 0;
  bit  msg_open = 1'b0;
  int  cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  murmur_hash_64a #(
    .LENGTH_WIDTH(LenW)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  mmh_digest_check #(
    .LENGTH_WIDTH(LenW)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .errors       (errors),
    .pending      (pending),
    .digests_seen (digests_seen),
    .flags_seen   (flags_seen)
  );

  // watchdog, a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d digests still expected", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // offer one item, with random idle cycles ahead of it unless calm
  task automatic offer_word(input logic [63:0] data, input logic [3:0] cnt, input logic first,
                            input logic last, input logic [LenW-1:0] total);
    if (!calm) begin
      while ($urandom_range(99) < 21) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(DataW - 68 - LenW){1'b0}}, total, cnt, data};
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    // track what the block should ignore, only for the summary
    if (first) begin
      msg_open = 1'b1;
    end else if (!msg_open) begin
      items_ignored++;
    end
    if (last) begin
      msg_open = 1'b0;
    end
    items_sent++;
  endtask

  // drop valid and wait until every digest has come back
  task automatic drain_digests();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  // seed register write, only with the block idle
  task automatic load_seed(input logic [63:0] value);
    drain_digests();
    // trailing non-last items may still be in flight without any digest to wait on
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    seeds_loaded++;
  endtask

  // one message split into words; wrong_len states a random length,
  // drop_last leaves it open so the next first item abandons it
  task automatic send_message(input int len, input bit wrong_len, input bit drop_last);
    int              n_words;
    int              idx;
    logic [3:0]      cnt;
    logic [LenW-1:0] stated;
    logic [LenW-1:0] total;
    stated  = wrong_len ? LenW'($urandom) : LenW'(len);
    n_words = (len == 0) ? 1 : (len + 7) / 8;
    for (idx = 0; idx < n_words; idx++) begin
      if (len == 0) begin
        cnt = 4'd0;
      end else if (idx < n_words - 1 || len % 8 == 0) begin
        cnt = 4'd8;
        // oversized counts behave as full words
        if ($urandom_range(9) == 0) begin
          cnt = 4'($urandom_range(15, 9));
        end
      end else begin
        cnt = 4'(len % 8);
      end
      // the length field is only read on the first word, fill it with noise elsewhere
      total = (idx == 0) ? stated : LenW'($urandom);
      offer_word(rand_word(), cnt, idx == 0, (idx == n_words - 1) && !drop_last, total);
    end
  endtask

  // mostly well-formed messages, some broken ones and some raw noise
  task automatic random_traffic(input int n_items);
    int goal;
    int pick;
    int len;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if ($urandom_range(99) < 70) begin
        len = $urandom_range(24);
      end else if ($urandom_range(99) < 85) begin
        len = $urandom_range(120, 25);
      end else begin
        len = $urandom_range(400, 121);
      end
      if (pick < 80) begin
        send_message(len, $urandom_range(9) == 0, 1'b0);
      end else if (pick < 88) begin
        send_message(len, $urandom_range(1), 1'b1);
      end else begin
        offer_word(rand_word(), 4'($urandom), 1'($urandom), 1'($urandom), LenW'($urandom));
      end
    end
  endtask

  // short directed messages covering the corners
  task automatic directed_items();
    offer_word(rand_word(), 4'd0, 1'b1, 1'b1, '0);              // empty message
    offer_word(rand_word(), 4'd0, 1'b1, 1'b1, LenW'(5));        // empty, stated length wrong
    offer_word(~64'd0, 4'd1, 1'b1, 1'b1, LenW'(1));             // one byte tail
    offer_word(rand_word(), 4'd7, 1'b1, 1'b1, LenW'(7));        // seven byte tail
    offer_word(~64'd0, 4'd8, 1'b1, 1'b1, LenW'(8));             // one full word, all ones
    offer_word(64'd0, 4'd8, 1'b1, 1'b1, '0);                    // all zero data, mismatch
    offer_word(rand_word(), 4'd15, 1'b1, 1'b1, '1);             // count 15 as 8, max length
    offer_word(64'd0, 4'd8, 1'b1, 1'b0, LenW'(11));             // two word message
    offer_word(rand_word(), 4'd3, 1'b0, 1'b1, LenW'($urandom));
    offer_word(rand_word(), 4'd8, 1'b0, 1'b1, '1);              // outside a message, dropped
    offer_word(rand_word(), 4'd5, 1'b0, 1'b0, '0);              // outside a message, dropped
    offer_word(rand_word(), 4'd8, 1'b1, 1'b0, LenW'(16));       // abandoned by the next first
    offer_word(rand_word(), 4'd8, 1'b1, 1'b1, LenW'(8));
    offer_word(rand_word(), 4'd3, 1'b1, 1'b0, LenW'(11));       // tail folded before the end
    offer_word(rand_word(), 4'd9, 1'b0, 1'b0, LenW'($urandom));
    offer_word(rand_word(), 4'd0, 1'b0, 1'b0, LenW'($urandom)); // empty word mid-message
    offer_word(rand_word(), 4'd0, 1'b0, 1'b1, LenW'($urandom)); // empty last word
    offer_word(rand_word(), 4'd12, 1'b1, 1'b1, LenW'(8));
    offer_word(rand_word(), 4'd8, 1'b1, 1'b0, LenW'(13));       // full word then 5 byte tail
    offer_word(~64'd0, 4'd5, 1'b0, 1'b1, '0);
  endtask

  // receiver: random stalls, no stalls when calm, and the long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 21);
      end
    end
  end

  // sender and verdict
  initial begin
    int idx;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners with a zero seed
    load_seed(64'd0);
    directed_items();

    // all-ones seed, then pile up single-word digests behind a stalled receiver
    load_seed(~64'd0);
    random_traffic(300);
    @(posedge clk);
    hold_requests++;
    for (idx = 0; idx < 16; idx++) begin
      offer_word(rand_word(), 4'($urandom_range(8)), 1'b1, 1'b1, LenW'($urandom_range(8)));
    end
    random_traffic(150);

    // random seed, with the sender pausing until nothing is outstanding
    load_seed(rand_word());
    random_traffic(200);
    drain_digests();
    random_traffic(250);

    // smallest nonzero seed, opening with a long stretch of back to back traffic
    load_seed(64'd1);
    calm = 1'b1;
    random_traffic(250);
    calm = 1'b0;
    random_traffic(200);

    // back to zero for the last stretch
    load_seed(64'd0);
    random_traffic(400);

    drain_digests();
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d items (%0d dropped outside a message) under %0d seed values",
             items_sent, items_ignored, seeds_loaded);
    $display("checked %0d digests, %0d of them with the length flag set",
             digests_seen, flags_seen);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/mmh_pkg.sv
hdl/mmh_mul.sv
hdl/mmh_datapath.sv
hdl/mmh_ctrl.sv
hdl/murmur_hash_64a.sv
tb/sv/mmh_digest_check.sv
tb/sv/tb_top.sv
